@@ hdl/srpe_pkg.sv @@
`timescale 1ns / 1ps

package srpe_pkg;

  // build defaults
  localparam int DEPTH_DEF       = 128;
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_LOW_TENTHS    = 2'd1,
    CFG_HIGH_TENTHS   = 2'd2
  } srpe_cfg_addr_t;

  localparam int SP_BITS     = 16;
  localparam int TENTHS_BITS = 4;

  localparam logic [SP_BITS-1:0]     SP_RST   = 16'd200;
  localparam logic [TENTHS_BITS-1:0] LOW_RST  = 4'd3;
  localparam logic [TENTHS_BITS-1:0] HIGH_RST = 4'd8;

  // request codes
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // result field widths and ceilings
  localparam int CNT_BITS = 7;
  localparam int AVG_BITS = 8;
  localparam int PER_BITS = 24;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [AVG_BITS-1:0] AVG_MAX = '1;
  localparam logic [PER_BITS-1:0] PER_MAX = '1;

  // measurement sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_THR,
    ST_SCAN,
    ST_DIVS,
    ST_DIVW,
    ST_MUL,
    ST_DONE
  } srpe_state_t;

endpackage

@@ hdl/srpe_in_if.sv @@
`timescale 1ns / 1ps

interface srpe_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

@@ hdl/srpe_out_if.sv @@
`timescale 1ns / 1ps

interface srpe_out_if;
  import srpe_pkg::*;

  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] cycle_count;
  logic [AVG_BITS-1:0] avg_run;
  logic [PER_BITS-1:0] period_us;
  logic                no_runs;

  modport source (output valid, output cycle_count, output avg_run,
                  output period_us, output no_runs, input ready);
  modport sink (input valid, input cycle_count, input avg_run,
                input period_us, input no_runs, output ready);
endinterface

@@ hdl/srpe_cfg_if.sv @@
`timescale 1ns / 1ps

interface srpe_cfg_if;
  import srpe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hdl/sample_ring_period_estimator_core.sv @@
`timescale 1ns / 1ps

// Sample ring period estimator. A store beat (op 0) writes the sample into a DEPTH-entry
// ring at a wrapping pointer. A measure beat (op 1) reads the whole ring twice through the
// single memory read port, first for the maximum and then for a hysteresis scan in storage
// order, divides the summed high-run length by the number of completed runs one bit per
// cycle, and scales by 2 * sample_period_us. A measure that finds no runs skips the divider
// and the multiply. A measure waits at its end while a still-held result has not left, and
// in_ready stays low for the whole measure. Slots never written since reset read as zero (a
// fill count tracks them), so no clearing pass is needed. The result waits in an output
// register, and store beats are still taken while it is held. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module sample_ring_period_estimator_core #(
  parameter int DEPTH       = srpe_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = srpe_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  srpe_in_if.sink     in_bus,
  srpe_out_if.source  out_bus,
  srpe_cfg_if.sink    cfg_bus
);
  import srpe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int TW = SAMPLE_BITS + 4;
  localparam int PW = FW + 1 + SP_BITS;

  // configuration registers
  logic [SP_BITS-1:0]     sp_r;
  logic [TENTHS_BITS-1:0] lo_r;
  logic [TENTHS_BITS-1:0] hi_r;

  // ring store
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q_r;
  logic [AW-1:0]          wptr_r, wptr_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;

  // sequencer and scan state
  srpe_state_t            state_r, state_nxt;
  logic [FW-1:0]          idx_r, idx_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [TW-1:0]          lo_thr_r, lo_thr_nxt;
  logic [TW-1:0]          hi_thr_r, hi_thr_nxt;
  logic                   high_r, high_nxt;
  logic [FW-1:0]          count_r, count_nxt;
  logic [FW-1:0]          sum_r, sum_nxt;
  logic [FW-1:0]          cyc_r, cyc_nxt;
  logic                   nocyc_r, nocyc_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_BITS-1:0]    out_cnt_r, out_cnt_nxt;
  logic [AVG_BITS-1:0]    out_avg_r, out_avg_nxt;
  logic [PER_BITS-1:0]    out_per_r, out_per_nxt;
  logic                   out_noc_r, out_noc_nxt;

  logic                   in_acc;
  logic                   mem_we;
  logic                   rd_en;
  logic [SAMPLE_BITS-1:0] smp;
  logic [TW-1:0]          s10;
  logic                   div_start;
  logic                   div_done;
  logic [FW-1:0]          div_quo;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign mem_we        = in_acc && (in_bus.op == OP_STORE);
  assign cfg_bus.ready = 1'b1;

  // read data, unwritten slots as zero, and its tenfold value
  assign smp = rd_ok_r ? mem_q_r : '0;
  assign s10 = (TW'(smp) << 3) + (TW'(smp) << 1);

  assign rd_en     = (state_r == ST_MAX || state_r == ST_SCAN) && (idx_r != FW'(DEPTH));
  assign div_start = (state_r == ST_DIVS);

  srpe_div #(
    .W (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cyc_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= SP_RST;
      lo_r <= LOW_RST;
      hi_r <= HIGH_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.addr)
        CFG_SAMPLE_PERIOD: sp_r <= cfg_bus.data;
        CFG_LOW_TENTHS:    lo_r <= cfg_bus.data[TENTHS_BITS-1:0];
        CFG_HIGH_TENTHS:   hi_r <= cfg_bus.data[TENTHS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= in_bus.sample;
    end
    mem_q_r <= mem[idx_r[AW-1:0]];
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = rd_en;
    rd_ok_nxt     = idx_r < fill_r;
    max_nxt       = max_r;
    lo_thr_nxt    = lo_thr_r;
    hi_thr_nxt    = hi_thr_r;
    high_nxt      = high_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    cyc_nxt       = cyc_r;
    nocyc_nxt     = nocyc_r;
    prod_nxt      = prod_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_avg_nxt   = out_avg_r;
    out_per_nxt   = out_per_r;
    out_noc_nxt   = out_noc_r;

    // result beat taken
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (mem_we) begin
          wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
          if (fill_r != FW'(DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else if (in_acc) begin
          idx_nxt   = '0;
          max_nxt   = '0;
          state_nxt = ST_MAX;
        end
      end

      // first walk: maximum
      ST_MAX: begin
        if (rd_pend_r && smp > max_r) begin
          max_nxt = smp;
        end
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = ST_THR;
        end
      end

      ST_THR: begin
        lo_thr_nxt = TW'(max_r) * TW'(lo_r);
        hi_thr_nxt = TW'(max_r) * TW'(hi_r);
        high_nxt   = 1'b0;
        count_nxt  = '0;
        sum_nxt    = '0;
        cyc_nxt    = '0;
        idx_nxt    = '0;
        state_nxt  = ST_SCAN;
      end

      // second walk: hysteresis runs
      ST_SCAN: begin
        if (rd_pend_r) begin
          if (high_r && s10 < lo_thr_r) begin
            high_nxt  = 1'b0;
            sum_nxt   = sum_r + count_r;
            count_nxt = '0;
            cyc_nxt   = cyc_r + 1'b1;
          end
          if (!high_nxt && s10 > hi_thr_r) begin
            high_nxt = 1'b1;
          end
          if (high_nxt) begin
            count_nxt = count_nxt + 1'b1;
          end
        end
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end else if (cyc_nxt == '0) begin
          nocyc_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          nocyc_nxt = 1'b0;
          state_nxt = ST_DIVS;
        end
      end

      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end

      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end

      // period = 2 * avg * sample period
      ST_MUL: begin
        prod_nxt  = PW'({div_quo, 1'b0}) * PW'(sp_r);
        state_nxt = ST_DONE;
      end

      // load result once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_noc_nxt   = nocyc_r;
          if (nocyc_r) begin
            out_cnt_nxt = '0;
            out_avg_nxt = '0;
            out_per_nxt = '0;
          end else begin
            out_cnt_nxt = (32'(cyc_r) > 32'(CNT_MAX)) ? CNT_MAX : CNT_BITS'(cyc_r);
            out_avg_nxt = (32'(div_quo) > 32'(AVG_MAX)) ? AVG_MAX : AVG_BITS'(div_quo);
            out_per_nxt = (32'(prod_r) > 32'(PER_MAX)) ? PER_MAX : PER_BITS'(prod_r);
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      wptr_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ok_r   <= rd_ok_nxt;
    max_r     <= max_nxt;
    lo_thr_r  <= lo_thr_nxt;
    hi_thr_r  <= hi_thr_nxt;
    high_r    <= high_nxt;
    count_r   <= count_nxt;
    sum_r     <= sum_nxt;
    cyc_r     <= cyc_nxt;
    nocyc_r   <= nocyc_nxt;
    prod_r    <= prod_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_avg_r <= out_avg_nxt;
    out_per_r <= out_per_nxt;
    out_noc_r <= out_noc_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.cycle_count = out_cnt_r;
  assign out_bus.avg_run     = out_avg_r;
  assign out_bus.period_us   = out_per_r;
  assign out_bus.no_runs     = out_noc_r;

`ifndef SYNTHESIS
  // empty result carries zero fields
  a_nocyc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_noc_r |-> out_cnt_r == '0 && out_avg_r == '0 && out_per_r == '0)
    else $error("no-cycle result with nonzero fields");

  // divider never started on a zero run count
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> cyc_r != '0)
    else $error("divide by zero run count");

  // write pointer and fill count stay in range
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wptr_r) < DEPTH && 32'(fill_r) <= DEPTH)
    else $error("ring pointer or fill count out of range");

  // store beat advances the fill count until full
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && fill_r != FW'(DEPTH) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("fill count did not advance");
`endif
endmodule

@@ hdl/srpe_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module srpe_div #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CTW = $clog2(W + 1);

  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           ge;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CTW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
